>>> hw/rtl/pst_pkg.sv
// Shared types, constants and match helpers for the primer search and trim block.
package pst_pkg;

  localparam int PRIMER_MAX = 24;
  localparam int SEQ_MAX    = 4096;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 13;
  localparam int LEN_W      = 5;
  localparam int SIDE_W     = 2;
  localparam int ST_W       = 2;
  localparam int GRP_SIZE   = 6;
  localparam int GRP_NUM    = PRIMER_MAX / GRP_SIZE;
  localparam int GRP_W      = 3;
  localparam int SCORE_W    = 5;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int PRIMER_W   = PRIMER_MAX * CHAR_W;
  localparam int REG_IDX_W  = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam char_t CH_Y = 8'h59;
  localparam char_t CH_C = 8'h43;
  localparam char_t CH_T = 8'h54;

  localparam logic [SIDE_W-1:0] SIDE_AFTER  = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_BEFORE = 2'd1;

  typedef enum logic [ST_W-1:0] {
    ST_HIT   = 2'd0,
    ST_NONE  = 2'd1,
    ST_SIDE  = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW  = 3'd0,
    REG_MID  = 3'd1,
    REG_HIGH = 3'd2,
    REG_LEN  = 3'd3,
    REG_MISM = 3'd4,
    REG_SIDE = 3'd5
  } reg_e;

  typedef struct packed {
    logic [PRIMER_W-1:0] primer;
    len_t                len;      // clamped to PRIMER_MAX
    len_t                allowed;
    logic [SIDE_W-1:0]   side;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic eval;
    cnt_t n;
  } stage_a_t;

  typedef struct packed {
    logic valid;
    logic hit;
    cnt_t cut;
    cnt_t n;
  } stage_b_t;

  function automatic logic is_ct(char_t c);
    return (c == CH_C) || (c == CH_T);
  endfunction

  // Y on either side stands for C or T; Y against Y is a mismatch.
  function automatic logic pos_match(char_t w, char_t p);
    logic m;
    if (w == CH_Y) m = is_ct(p);
    else if (p == CH_Y) m = is_ct(w);
    else m = (w == p);
    return m;
  endfunction

  function automatic char_t primer_char(logic [PRIMER_W-1:0] primer, len_t idx);
    char_t c;
    c = '0;
    if (idx < LEN_W'(PRIMER_MAX)) c = primer[idx*CHAR_W +: CHAR_W];
    return c;
  endfunction

endpackage

>>> hw/rtl/pst_in_if.sv
// Input channel: one sequence character per beat.
interface pst_in_if;
  import pst_pkg::*;

  logic  valid;
  logic  ready;
  char_t seq_char;
  logic  is_last;

  modport source (output valid, seq_char, is_last, input ready);
  modport sink   (input valid, seq_char, is_last, output ready);
endinterface

>>> hw/rtl/pst_out_if.sv
// Output channel: one trim result per beat.
interface pst_out_if;
  import pst_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  cnt_t             keep_start;
  cnt_t             keep_length;

  modport source (output valid, status, keep_start, keep_length, input ready);
  modport sink   (input valid, status, keep_start, keep_length, output ready);
endinterface

>>> hw/rtl/primer_search_trim.sv
// Top level of the streaming primer search and trim block.
//
// Usage:
//   seq_i carries one sequence character per beat, with is_last on the final
//   character. res_o carries one beat per sequence, after its last character:
//   status (hit, no hit, invalid side, primer not shorter than sequence) and
//   the region to keep. The APB port sets the primer (up to 24 characters),
//   its length, the tolerated mismatches and the trim side; write it only
//   while no sequence is in flight.
// Throughput: one character per cycle while res_o is not stalled, sequences back to back with no gap.
//   A row of 24 cells shifts the window and flags per-position matches; the
//   popcount of those flags is the only wide logic.
// Pipeline: the result for a last character passes the cell row, the score
//   stage and the output register before it is on res_o.
// Stall: when a result waits on res_o, seq_i.ready drops in the same cycle
//   and the whole pipeline holds; nothing is lost.
// Reset: all settings, the window, counters and the output valid clear; the
//   block is ready in the first cycle after reset.
module primer_search_trim (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pst_pkg::ADDR_W-1:0] paddr,
  input  logic [pst_pkg::DATA_W-1:0] pwdata,
  output logic [pst_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  pst_in_if.sink                     seq_i,
  pst_out_if.source                  res_o
);
  import pst_pkg::*;

  cfg_t                  cfg;
  logic                  adv;       // pipeline advances
  logic                  accept;
  logic                  stored;    // character fits below SEQ_MAX
  logic                  shift;
  cnt_t                  cnt_q, cnt_d, n_new;
  stage_a_t              a_q, a_d;
  stage_b_t              b;
  char_t                 win [PRIMER_MAX];
  logic [PRIMER_MAX-1:0] match;

  status_e               st_d;
  cnt_t                  start_d, klen_d;
  logic                  out_valid_q;
  status_e               st_q;
  cnt_t                  start_q, klen_q;

  pst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Global stall: everything holds while a result beat is refused.
  assign adv         = !out_valid_q || res_o.ready;
  assign seq_i.ready = adv;
  assign accept      = seq_i.valid && adv;

  // Characters past SEQ_MAX are neither counted nor stored.
  assign stored = cnt_q < CNT_W'(SEQ_MAX);
  assign n_new  = stored ? cnt_q + 1'b1 : cnt_q;
  assign shift  = accept && stored;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) cnt_d = seq_i.is_last ? '0 : n_new;
  end

  always_comb begin
    a_d.valid = accept;
    a_d.last  = seq_i.is_last;
    a_d.eval  = stored && (cfg.len != '0) && (n_new >= CNT_W'(cfg.len));
    a_d.n     = n_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      a_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (adv) a_q <= a_d;
    end
  end

  // Cell j holds the character j beats back and compares it with primer
  // character len-1-j, so the row lines up the whole window in one step.
  for (genvar j = 0; j < PRIMER_MAX; j++) begin : g_cell
    char_t cin;
    len_t  pidx;
    logic  active;

    if (j == 0) begin : g_head
      assign cin = seq_i.seq_char;
    end else begin : g_body
      assign cin = win[j-1];
    end

    assign pidx   = cfg.len - LEN_W'(j + 1);
    assign active = LEN_W'(j) < cfg.len;

    pst_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .char_i   (cin),
      .pchar_i  (primer_char(cfg.primer, pidx)),
      .active_i (active),
      .char_o   (win[j]),
      .match_o  (match[j])
    );
  end

  pst_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .a_i     (a_q),
    .match_i (match),
    .cfg_i   (cfg),
    .b_o     (b)
  );

  // Result: invalid side first, then a primer too long for the sequence.
  always_comb begin
    start_d = '0;
    klen_d  = '0;
    if (cfg.side > SIDE_BEFORE) begin
      st_d = ST_SIDE;
    end else if (CNT_W'(cfg.len) >= b.n) begin
      st_d = ST_SHORT;
    end else if (b.hit) begin
      st_d = ST_HIT;
      if (cfg.side == SIDE_AFTER) begin
        start_d = b.cut;
        klen_d  = b.n - b.cut;
      end else begin
        klen_d  = b.cut - 1'b1;
      end
    end else begin
      st_d = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q    <= st_d;
      start_q <= start_d;
      klen_q  <= klen_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = st_q;
  assign res_o.keep_start  = start_q;
  assign res_o.keep_length = klen_q;

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without a blocked result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SEQ_MAX))
    else $error("character count above limit");

  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_i.valid && seq_i.ready && seq_i.is_last) |=> (cnt_q == '0))
    else $error("count not cleared after last character");

  a_eval_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q.valid && a_q.eval) |-> ((cfg.len != '0) && (a_q.n >= CNT_W'(cfg.len))))
    else $error("window scored before it was full");

  a_no_region_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != ST_HIT)) |->
      ((res_o.keep_start == '0) && (res_o.keep_length == '0)))
    else $error("region given without a hit");
`endif

endmodule

>>> hw/rtl/pst_cfg.sv
// APB register file holding the primer and search settings.
module pst_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pst_pkg::ADDR_W-1:0] paddr,
  input  logic [pst_pkg::DATA_W-1:0] pwdata,
  output logic [pst_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pst_pkg::cfg_t              cfg_o
);
  import pst_pkg::*;

  logic [DATA_W-1:0] low_q, mid_q, high_q;
  len_t              len_q, mism_q;
  logic [SIDE_W-1:0] side_q;
  logic              wr_en;
  reg_e              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_e'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      mid_q  <= '0;
      high_q <= '0;
      len_q  <= '0;
      mism_q <= '0;
      side_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOW:  low_q  <= pwdata;
        REG_MID:  mid_q  <= pwdata;
        REG_HIGH: high_q <= pwdata;
        REG_LEN:  len_q  <= pwdata[LEN_W-1:0];
        REG_MISM: mism_q <= pwdata[LEN_W-1:0];
        REG_SIDE: side_q <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LOW:  prdata = low_q;
      REG_MID:  prdata = mid_q;
      REG_HIGH: prdata = high_q;
      REG_LEN:  prdata = DATA_W'(len_q);
      REG_MISM: prdata = DATA_W'(mism_q);
      REG_SIDE: prdata = DATA_W'(side_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.primer  = {high_q, mid_q, low_q};
  assign cfg_o.len     = (len_q > LEN_W'(PRIMER_MAX)) ? LEN_W'(PRIMER_MAX) : len_q;
  assign cfg_o.allowed = mism_q;
  assign cfg_o.side    = side_q;

endmodule

>>> hw/rtl/pst_cell.sv
// One window cell: holds a character, passes it on, and flags a primer match.
module pst_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  pst_pkg::char_t char_i,
  input  pst_pkg::char_t pchar_i,
  input  logic           active_i,
  output pst_pkg::char_t char_o,
  output logic           match_o
);
  import pst_pkg::*;

  char_t char_q;
  logic  match_q;

  // match is taken on the incoming character so it lines up with char_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q  <= '0;
      match_q <= 1'b0;
    end else if (shift_i) begin
      char_q  <= char_i;
      match_q <= active_i && pos_match(char_i, pchar_i);
    end
  end

  assign char_o  = char_q;
  assign match_o = match_q;

endmodule

>>> hw/rtl/pst_score.sv
// Window score, first-hit tracking and end-of-sequence hand-off.
module pst_score (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  pst_pkg::stage_a_t               a_i,
  input  logic [pst_pkg::PRIMER_MAX-1:0]  match_i,
  input  pst_pkg::cfg_t                   cfg_i,
  output pst_pkg::stage_b_t               b_o
);
  import pst_pkg::*;

  logic [GRP_W-1:0]   grp [GRP_NUM];
  logic [SCORE_W-1:0] score;
  logic               pass_ok;
  logic               hit_now;
  logic               hit_q;
  cnt_t               cut_q;
  stage_b_t           b_q;

  // two-level popcount: groups of six, then the group sums
  always_comb begin
    for (int g = 0; g < GRP_NUM; g++) begin
      grp[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp[g] = grp[g] + GRP_W'(match_i[g*GRP_SIZE+k]);
      end
    end
    score = '0;
    for (int g = 0; g < GRP_NUM; g++) begin
      score = score + SCORE_W'(grp[g]);
    end
  end

  // score >= len - allowed, kept unsigned
  assign pass_ok = ((LEN_W+1)'(score) + (LEN_W+1)'(cfg_i.allowed)) >= (LEN_W+1)'(cfg_i.len);
  assign hit_now = a_i.valid && a_i.eval && !hit_q && pass_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      cut_q <= '0;
      b_q   <= '0;
    end else if (adv_i) begin
      b_q.valid <= a_i.valid && a_i.last;
      b_q.hit   <= hit_q || hit_now;
      b_q.cut   <= hit_now ? a_i.n : cut_q;
      b_q.n     <= a_i.n;
      if (a_i.valid) begin
        if (a_i.last) begin
          hit_q <= 1'b0;
        end else if (hit_now) begin
          hit_q <= 1'b1;
          cut_q <= a_i.n;
        end
      end
    end
  end

  assign b_o = b_q;

endmodule
